@@ hw/rtl/ils_pkg.sv @@
// ils_pkg: shared types and constants for the indexed list store.
// Used by ils_ctrl, ils_dp and indexed_list_store; no dependencies.
`default_nettype none

package ils_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned LEN_W        = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the incoming word
    logic exec;   // carry out the held operation, load result register
  } ils_cmd_t;

endpackage : ils_pkg

`default_nettype wire

@@ hw/rtl/ils_dp.sv @@
// ils_dp: item register, entry register array, count and result register.
// Depends on ils_pkg; driven by ils_ctrl through ils_cmd_t.
`default_nettype none

module ils_dp #(
  parameter int unsigned CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire ils_pkg::ils_cmd_t                cmd_i,
  input  wire logic [ils_pkg::OP_W-1:0]         operation_i,
  input  wire logic [ils_pkg::POS_W-1:0]        position_i,
  input  wire logic signed [ils_pkg::DATA_W-1:0] item_value_i,
  output logic [ils_pkg::STAT_W-1:0]            status_o,
  output logic signed [ils_pkg::DATA_W-1:0]     read_value_o,
  output logic [ils_pkg::LEN_W-1:0]             list_length_o
);
  import ils_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // held operation
  op_e                op_q;
  logic [POS_W-1:0]   pos_q;
  logic [DATA_W-1:0]  val_q;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [DATA_W-1:0]  entries_q [CAPACITY];
  logic [DATA_W-1:0]  entries_d [CAPACITY];

  status_e            status_q, status_d;
  logic [DATA_W-1:0]  rd_q, rd_d;
  logic [LEN_W-1:0]   len_q;

  logic [CMP_W-1:0]   pos_c, cnt_c, cnt_next_c;
  logic               do_insert, do_remove, do_update;

  assign pos_c = CMP_W'(pos_q);
  assign cnt_c = CMP_W'(count_q);

  always_comb begin
    status_d   = STAT_OK;
    rd_d       = '0;
    cnt_next_c = cnt_c;
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    do_update  = 1'b0;
    unique case (op_q)
      OP_INSERT: begin
        if (pos_c > cnt_c) begin
          status_d = STAT_RANGE;
        end else if (cnt_c >= CMP_W'(CAPACITY)) begin
          status_d = STAT_FULL;
        end else begin
          do_insert  = 1'b1;
          cnt_next_c = cnt_c + CMP_W'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_c >= cnt_c) begin
          status_d = STAT_RANGE;
        end else begin
          do_remove  = 1'b1;
          cnt_next_c = cnt_c - CMP_W'(1);
        end
      end
      OP_UPDATE: begin
        if (pos_c >= cnt_c) begin
          status_d = STAT_RANGE;
        end else begin
          do_update = 1'b1;
        end
      end
      OP_READ: begin
        if (pos_c >= cnt_c) begin
          status_d = STAT_RANGE;
        end else begin
          rd_d = entries_q[pos_c[IDX_W-1:0]];
        end
      end
      default: status_d = STAT_RANGE;
    endcase
  end

  assign count_d = cnt_next_c[CNT_W-1:0];

  // per-entry next value: each slot sees only itself and its neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    logic above_pos, at_pos;
    assign above_pos = pos_c < CMP_W'(i);
    assign at_pos    = pos_c == CMP_W'(i);

    always_comb begin
      entries_d[i] = entries_q[i];
      if ((do_insert || do_update) && at_pos) begin
        entries_d[i] = val_q;
      end else if (do_insert && above_pos) begin
        if (i > 0) begin
          entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_remove && (above_pos || at_pos)) begin
        if (i < CAPACITY - 1) begin
          entries_d[i] = entries_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(operation_i);
      pos_q <= position_i;
      val_q <= item_value_i;
    end
    if (cmd_i.exec) begin
      entries_q <= entries_d;
      status_q  <= status_d;
      rd_q      <= rd_d;
      len_q     <= cnt_next_c[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign status_o      = status_q;
  assign read_value_o  = rd_q;
  assign list_length_o = len_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && do_insert |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && do_remove |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("remove did not shrink the list");

endmodule : ils_dp

`default_nettype wire

@@ hw/rtl/ils_ctrl.sv @@
// ils_ctrl: two-state controller, input/output handshakes, result valid.
// Depends on ils_pkg; commands ils_dp through ils_cmd_t.
`default_nettype none

module ils_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ils_pkg::ils_cmd_t      cmd_o
);
  import ils_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result slot can take a word if empty or being drained this cycle
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b0;
    cmd_o.exec  = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
      end
      S_EXEC: begin
        in_stall_o = !slot_free;
        cmd_o.exec = slot_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    cmd_o.load = in_valid_i && !in_stall_o;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end
    if (cmd_o.load) begin
      state_d = S_EXEC;
    end else if (cmd_o.exec) begin
      state_d = S_IDLE;
    end
  end

  assign out_valid_o = out_valid_q;

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("executed word produced no result");

  a_stall_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> state_q == S_EXEC && out_valid_q)
    else $error("input stalled with nothing pending");

  a_load_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_EXEC)
    else $error("accepted word not held for execution");

endmodule : ils_ctrl

`default_nettype wire

@@ hw/rtl/indexed_list_store.sv @@
// indexed_list_store: bounded positional list of signed 32-bit entries.
// Usage notes:
//  - Input channel (in_valid_i / in_stall_o) carries one word: operation,
//    position and item value. Insert, remove, update or read at a position.
//  - Output channel (out_valid_o / out_stall_i) returns one word per input:
//    status (ok, out of range, full), read value (zero unless a good read)
//    and the list length after the operation.
//  - An accepted word is held in the item register and executed into the
//    result register once the slot is free; shown there until taken.
//  - Throughput: one word per cycle if unstalled. The entry register array
//    shift and the result register both complete in the execute cycle.
//  - A stalled result is held in the result register; the executing word
//    waits for the slot, and only then is the input stalled. One further
//    word is held ahead of the result slot.
//  - Reset (rst_ni low, asynchronous) empties the list and drops any
//    pending word; entry contents are not cleared and are only seen after
//    being written.
// Depends on ils_pkg, ils_ctrl and ils_dp.
`default_nettype none

module indexed_list_store #(
  parameter int unsigned CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [ils_pkg::OP_W-1:0]          operation_i,
  input  wire logic [ils_pkg::POS_W-1:0]         position_i,
  input  wire logic signed [ils_pkg::DATA_W-1:0] item_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [ils_pkg::STAT_W-1:0]             status_o,
  output logic signed [ils_pkg::DATA_W-1:0]      read_value_o,
  output logic [ils_pkg::LEN_W-1:0]              list_length_o
);
  import ils_pkg::*;

  ils_cmd_t cmd;

  // controller: handshakes and sequencing
  ils_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // datapath: entry array, count, result register
  ils_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .list_length_o (list_length_o)
  );

endmodule : indexed_list_store

`default_nettype wire

@@ verif/testbench.sv @@
// testbench: self-checking bench for indexed_list_store. Drives insert, remove,
// update and read words and checks each result word against a shadow list.
// Depends on ils_pkg and the indexed_list_store RTL; reads no files.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  localparam int DEPTH          = CAPACITY_DEF;
  localparam int WATCHDOG_LIMIT = 5000; // cycles with no word moving on either side
  localparam int DRAIN_CYCLES   = 10;   // margin after the last result has come back
  localparam int MIX_SPAN       = 40;   // words per traffic mix before switching

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // traffic mixes for the random part: grow the list, shrink it, or neither
  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} traffic_mix_e;

  // one expected result word
  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [OP_W-1:0]          operation_i;
  logic [POS_W-1:0]         position_i;
  logic signed [DATA_W-1:0] item_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [STAT_W-1:0]        status_o;
  logic signed [DATA_W-1:0] read_value_o;
  logic [LEN_W-1:0]         list_length_o;

  // shadow copy of the list, updated as each input word is accepted
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int                       shadow_count = 0;

  list_result_t expected_results[$];

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;

  int fail_count      = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int full_seen       = 0;
  int range_seen      = 0;
  int peak_count      = 0;
  int quiet_cycles    = 0;

  indexed_list_store dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .list_length_o (list_length_o)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Applies one operation to the shadow list and returns the result word.
  // Insert checks the position before fullness; the others refuse any
  // position at or past the count, which covers the empty list.
  function automatic list_result_t apply_list_op(op_e op, logic [POS_W-1:0] pos,
                                                 logic signed [DATA_W-1:0] value);
    list_result_t res;
    int           p;
    int           i;
    res.status     = STAT_OK;
    res.read_value = '0;
    p              = int'(pos);
    if (op == OP_INSERT) begin
      if (p > shadow_count) begin
        res.status = STAT_RANGE;
      end else if (shadow_count >= DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        for (i = shadow_count; i > p; i--) shadow_entries[i] = shadow_entries[i - 1];
        shadow_entries[p] = value;
        shadow_count++;
      end
    end else if (p >= shadow_count) begin
      res.status = STAT_RANGE;
    end else if (op == OP_REMOVE) begin
      for (i = p; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
      shadow_count--;
    end else if (op == OP_UPDATE) begin
      shadow_entries[p] = value;
    end else begin
      res.read_value = shadow_entries[p];
    end
    res.length = LEN_W'(shadow_count);
    return res;
  endfunction

  // Input side: predict on every accepted word.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_results.push_back(apply_list_op(op_e'(operation_i), position_i,
                                               item_value_i));
      words_sent++;
      if (shadow_count > peak_count) peak_count = shadow_count;
    end
  end

  // Output side: compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin : check_result
    list_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: status %0d length %0d",
               status_o, list_length_o);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
        if (read_value_o !== want.read_value) begin
          $error("read_value: expected %0d, actual %0d", want.read_value, read_value_o);
          fail_count++;
        end
        if (list_length_o !== want.length) begin
          $error("list_length: expected %0d, actual %0d", want.length, list_length_o);
          fail_count++;
        end
        if (want.status == STAT_FULL) full_seen++;
        if (want.status == STAT_RANGE) range_seen++;
        results_checked++;
      end
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: stalls at random, at the rate the current phase sets.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= rst_ni && ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // Sends one word, with random idle cycles ahead of it; returns at the
  // edge where it is taken. Payload holds steady while stalled.
  task automatic send_word(op_e op, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    position_i   <= pos;
    item_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Sender holds off until every expected result has come back.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  // Nothing stored yet: every access is out of range, as is inserting past
  // the count; position 31 drives the top position bit.
  task automatic test_empty_list();
    send_word(OP_READ,   5'd0,  32'sd0);
    send_word(OP_REMOVE, 5'd0,  32'sd0);
    send_word(OP_UPDATE, 5'd0,  VAL_MAX);
    send_word(OP_INSERT, 5'd1,  VAL_MIN);
    send_word(OP_INSERT, 5'd31, -32'sd1);
  endtask

  // Insert at the head, append at the count, insert in the middle; read back.
  task automatic test_insert_positions();
    int i;
    send_word(OP_INSERT, 5'd0, VAL_MIN);
    send_word(OP_INSERT, 5'd1, VAL_MAX);
    send_word(OP_INSERT, 5'd0, -32'sd1);
    send_word(OP_INSERT, 5'd1, 32'sd0);
    for (i = 0; i <= 4; i++) send_word(OP_READ, POS_W'(i), 32'sd0);
  endtask

  // Overwrite, then remove the last, a middle and the first entry, down to empty.
  task automatic test_update_remove();
    send_word(OP_UPDATE, 5'd3, 32'sh5555_5555);
    send_word(OP_UPDATE, 5'd4, 32'sh2aaa_aaaa);
    send_word(OP_READ,   5'd3, 32'sd0);
    send_word(OP_REMOVE, 5'd3, 32'sd0);
    send_word(OP_REMOVE, 5'd1, 32'sd0);
    send_word(OP_REMOVE, 5'd0, 32'sd0);
    send_word(OP_READ,   5'd0, 32'sd0);
    send_word(OP_REMOVE, 5'd0, 32'sd0);
    send_word(OP_REMOVE, 5'd0, 32'sd0);
  endtask

  // Random words under the given idle rates. The mix cycles so the list
  // fills up (and hits full) and drains back (and hits empty) repeatedly.
  // Halfway through, the sender waits for all results to drain.
  task automatic test_random_traffic(int n_words, int snd_pct, int rcv_pct);
    traffic_mix_e             mix;
    op_e                      op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
    int                       k;
    int                       r;
    wait_for_results();
    sender_idle_pct   = snd_pct;
    receiver_idle_pct = rcv_pct;
    for (k = 0; k < n_words; k++) begin
      case ((k / MIX_SPAN) % 4)
        0:       mix = MIX_FILL;
        2:       mix = MIX_DRAIN;
        default: mix = MIX_BALANCED;
      endcase
      r = $urandom_range(99);
      case (mix)
        MIX_FILL:  op = (r < 60) ? OP_INSERT : (r < 70) ? OP_REMOVE :
                        (r < 85) ? OP_UPDATE : OP_READ;
        MIX_DRAIN: op = (r < 15) ? OP_INSERT : (r < 65) ? OP_REMOVE :
                        (r < 80) ? OP_UPDATE : OP_READ;
        default:   op = (r < 30) ? OP_INSERT : (r < 55) ? OP_REMOVE :
                        (r < 75) ? OP_UPDATE : OP_READ;
      endcase
      // position: mostly in range, some right at the count, some anywhere
      r = $urandom_range(99);
      if (r < 8) begin
        pos = POS_W'($urandom_range(31));
      end else if (r < 16) begin
        pos = POS_W'(shadow_count);
      end else if (op == OP_INSERT) begin
        pos = POS_W'($urandom_range(shadow_count));
      end else begin
        pos = (shadow_count == 0) ? '0 : POS_W'($urandom_range(shadow_count - 1));
      end
      r = $urandom_range(99);
      case (r)
        0:       value = VAL_MIN;
        1:       value = VAL_MAX;
        2:       value = 32'sd0;
        3:       value = -32'sd1;
        default: value = $urandom;
      endcase
      send_word(op, pos, value);
      if (k == n_words / 2) wait_for_results();
    end
  endtask

  initial begin : stimulus
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    operation_i  = OP_READ;
    position_i   = '0;
    item_value_i = '0;
    for (int i = 0; i < DEPTH; i++) shadow_entries[i] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_insert_positions();
    test_update_remove();
    test_random_traffic(650, 22, 86); // slow-ish sender, heavily stalled receiver
    test_random_traffic(650, 86, 22); // sparse sender, lightly stalled receiver
    test_random_traffic(650, 0, 0);   // back to back

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d words and %0d results: %0d full-list and %0d out-of-range",
             words_sent, results_checked, full_seen, range_seen);
    $display("refusals, peak length %0d, under three sender/receiver idling mixes.",
             peak_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ indexed_list_store.f @@
hw/rtl/ils_pkg.sv
hw/rtl/ils_dp.sv
hw/rtl/ils_ctrl.sv
hw/rtl/indexed_list_store.sv
verif/testbench.sv
